// File: design/ceq_pkg.sv
// Shared types, codes and defaults for the calendar event queue.
package ceq_pkg;

	localparam int POOL_DEPTH_D     = 256;
	localparam int MAX_BUCKETS_D    = 1024;
	localparam int BUCKET_UNIT_D    = 16;
	localparam int TIME_FRAC_BITS_D = 8;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_GET    = 2'd1,
		MODE_REMOVE = 2'd2,
		MODE_UNUSED = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		ST_INSERTED  = 4'd0,
		ST_LATE      = 4'd1,
		ST_PAST      = 4'd2,
		ST_FULL      = 4'd3,
		ST_DELIVERED = 4'd4,
		ST_NONE      = 4'd5,
		ST_SKIPPED   = 4'd6,
		ST_REMOVED   = 4'd7,
		ST_NOTFOUND  = 4'd8
	} status_t;

	typedef enum logic {
		REG_NUM_BUCKETS = 1'b0,
		REG_LATE_LIMIT  = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] event_time;
		logic [15:0] node_id;
		logic [15:0] event_tag;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [31:0] out_time;
		logic [15:0] out_node_id;
		logic [15:0] out_tag;
	} out_item_t;

	// Fixed part of a pool entry; the bucket index is appended in the RAM word.
	typedef struct packed {
		logic [31:0] etime;
		logic [15:0] node;
		logic [15:0] handle;
		logic [31:0] order;
	} entry_t;

endpackage

// File: design/ceq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ceq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: design/ceq_div.sv
// Restoring divider, one quotient bit per cycle; gives the remainder.
module ceq_div #(
	parameter int NW = 24,
	parameter int DW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [DW-1:0] rem
);

	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [DW:0]   trial;
	logic          ge;

	assign trial = {rem_q, quo_q[NW-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (cnt_q == CW'(NW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], ge};
			rem_q <= ge ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// File: design/calendar_event_queue.sv
// Calendar event queue: event pool in RAM, sequencer scanning it per item.
//
// Input channel in_valid/in_stall/in_item carries one command (insert, get,
// remove); output channel out_valid/out_stall/out_item returns exactly one
// result per command. A transfer happens when valid is high and stall low.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data).
// Insert, get and remove raise out_valid after a reciprocal multiply for the
// bucket unit count, the serial divider for the modulo by the bucket count,
// then one pass over the pool RAM, one entry per cycle, through its single
// read port. The next command is taken once the sequencer is back in idle.
// Late or past inserts and the unused mode go straight to the response state;
// a get whose bucket is skipped answers once the divider is done, with no scan.
// One command is in flight at a time; in_stall is high while it is worked.
// A finished result sits in the output register; the next command is taken
// while it waits, and its result is held back until out_stall drops.
// Reset clears the valid bits of the pool, the sequence counter, the current
// time and last bucket, and sets num_buckets to 1024, the late limit to all ones.
module calendar_event_queue #(
	parameter int POOL_DEPTH     = ceq_pkg::POOL_DEPTH_D,
	parameter int MAX_BUCKETS    = ceq_pkg::MAX_BUCKETS_D,
	parameter int BUCKET_UNIT    = ceq_pkg::BUCKET_UNIT_D,
	parameter int TIME_FRAC_BITS = ceq_pkg::TIME_FRAC_BITS_D
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ceq_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output ceq_pkg::out_item_t out_item,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int PW = $clog2(POOL_DEPTH);
	localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam int NW = 32 - TIME_FRAC_BITS;
	localparam int LU = $clog2(BUCKET_UNIT);
	localparam int SH = NW + LU;
	localparam int PRW = SH + NW;
	localparam logic [NW:0] RECIP = (NW + 1)'(((64'd1 << SH) + 64'(BUCKET_UNIT) - 64'd1) /
		64'(BUCKET_UNIT));
	localparam int MW = $clog2(MAX_BUCKETS + 1);
	localparam int DW = MW;
	localparam int EW = $bits(ceq_pkg::entry_t) + BW;
	localparam logic [32:0] UNIT_SPAN = 33'(BUCKET_UNIT) << TIME_FRAC_BITS;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_DIV1   = 7'b0000010,
		S_DIV2   = 7'b0000100,
		S_SCAN   = 7'b0001000,
		S_LAST   = 7'b0010000,
		S_FINISH = 7'b0100000,
		S_RESP   = 7'b1000000
	} state_t;

	state_t             state_q;
	ceq_pkg::in_item_t  item_q;
	ceq_pkg::out_item_t res_q;
	ceq_pkg::out_item_t out_q;
	logic               out_valid_q;
	logic [10:0]        num_buckets_q;
	logic [31:0]        late_limit_q;
	logic [31:0]        seq_q;
	logic [31:0]        now_q;
	logic [BW-1:0]      last_q;
	logic [BW-1:0]      bkt_q;
	logic [POOL_DEPTH-1:0] valid_q;
	logic [PW-1:0]      scan_q;
	logic               eval_s1;
	logic               vld_s1;
	logic [PW-1:0]      idx_s1;
	logic               found_q;
	logic [PW-1:0]      pick_q;
	logic [31:0]        pick_time_q;
	logic [31:0]        pick_age_q;
	logic [15:0]        pick_node_q;
	logic [15:0]        pick_tag_q;

	logic               accept;
	logic               go_div;
	logic [PRW-1:0]     unit_prod;
	logic               div_start;
	logic [NW-1:0]      div_num;
	logic [DW-1:0]      div_den;
	logic               div_done;
	logic [DW-1:0]      div_rem;
	logic [DW-1:0]      nb;
	logic [BW-1:0]      new_bkt;
	logic               skip;
	logic               ram_we;
	logic [EW-1:0]      ram_wdata;
	logic [EW-1:0]      ram_rdata;
	ceq_pkg::entry_t    rd_entry;
	logic [BW-1:0]      rd_bkt;
	logic [31:0]        rd_age;
	logic               hit;
	logic               due;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		if (num_buckets_q == 11'd0) begin
			nb = DW'(1);
		end else if (32'(num_buckets_q) > 32'(MAX_BUCKETS)) begin
			nb = DW'(MAX_BUCKETS);
		end else begin
			nb = DW'(num_buckets_q);
		end
	end

	assign go_div = (in_item.mode == ceq_pkg::MODE_INSERT ||
		in_item.mode == ceq_pkg::MODE_GET || in_item.mode == ceq_pkg::MODE_REMOVE) &&
		!(in_item.mode == ceq_pkg::MODE_INSERT &&
		(in_item.event_time > late_limit_q || now_q > in_item.event_time));

	// unit count = whole time / BUCKET_UNIT by reciprocal multiply
	assign unit_prod = PRW'(item_q.event_time[31:TIME_FRAC_BITS]) * PRW'(RECIP);

	assign div_start = (state_q == S_DIV1);
	assign div_num   = unit_prod[PRW-1:SH];
	assign div_den   = nb;

	ceq_div #(
		.NW(NW),
		.DW(DW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.rem   (div_rem)
	);

	assign new_bkt = div_rem[BW-1:0];
	assign skip    = {1'b0, new_bkt} > ({1'b0, last_q} + (BW+1)'(1));

	assign ram_we    = (state_q == S_FINISH) && (item_q.mode == ceq_pkg::MODE_INSERT) && found_q;
	assign ram_wdata = {item_q.event_time, item_q.node_id, item_q.event_tag, seq_q, bkt_q};

	ceq_ram #(
		.WIDTH(EW),
		.DEPTH(POOL_DEPTH)
	) u_pool (
		.clk  (clk),
		.we   (ram_we),
		.waddr(pick_q),
		.wdata(ram_wdata),
		.raddr(scan_q),
		.rdata(ram_rdata)
	);

	assign rd_entry = ram_rdata[EW-1:BW];
	assign rd_bkt   = ram_rdata[BW-1:0];
	assign rd_age   = seq_q - rd_entry.order;

	always_comb begin
		case (item_q.mode)
			ceq_pkg::MODE_INSERT: hit = !vld_s1 && !found_q;
			ceq_pkg::MODE_GET: hit = vld_s1 && rd_bkt == bkt_q && (!found_q ||
				rd_entry.etime < pick_time_q ||
				(rd_entry.etime == pick_time_q && rd_age > pick_age_q));
			ceq_pkg::MODE_REMOVE: hit = vld_s1 && rd_entry.etime == item_q.event_time &&
				rd_entry.handle == item_q.event_tag && (!found_q || rd_age > pick_age_q);
			default: hit = 1'b0;
		endcase
	end

	assign due = found_q && ({1'b0, pick_time_q} <= ({1'b0, item_q.event_time} + UNIT_SPAN));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			out_valid_q   <= 1'b0;
			num_buckets_q <= 11'd1024;
			late_limit_q  <= 32'hFFFF_FFFF;
			seq_q         <= '0;
			now_q         <= '0;
			last_q        <= '0;
			valid_q       <= '0;
			scan_q        <= '0;
			eval_s1       <= 1'b0;
			found_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					ceq_pkg::REG_NUM_BUCKETS: num_buckets_q <= cfg_data[10:0];
					ceq_pkg::REG_LATE_LIMIT:  late_limit_q  <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == S_RESP && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			eval_s1 <= (state_q == S_SCAN);
			if (eval_s1 && hit) begin
				found_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (go_div) begin
							state_q <= S_DIV1;
						end else begin
							state_q <= S_RESP;
						end
					end
				end
				S_DIV1: begin
					state_q <= S_DIV2;
				end
				S_DIV2: begin
					if (div_done) begin
						scan_q  <= '0;
						found_q <= 1'b0;
						if (item_q.mode == ceq_pkg::MODE_GET) begin
							last_q <= new_bkt;
							now_q  <= item_q.event_time;
						end
						if (item_q.mode == ceq_pkg::MODE_GET && skip) begin
							state_q <= S_RESP;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (scan_q == PW'(POOL_DEPTH - 1)) begin
						state_q <= S_LAST;
					end else begin
						scan_q <= scan_q + PW'(1);
					end
				end
				S_LAST: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					state_q <= S_RESP;
					case (item_q.mode)
						ceq_pkg::MODE_INSERT: begin
							if (found_q) begin
								valid_q[pick_q] <= 1'b1;
								seq_q           <= seq_q + 32'd1;
							end
						end
						ceq_pkg::MODE_GET, ceq_pkg::MODE_REMOVE: begin
							if (due || (found_q && item_q.mode == ceq_pkg::MODE_REMOVE)) begin
								valid_q[pick_q] <= 1'b0;
							end
						end
						default: ;
					endcase
				end
				S_RESP: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q            <= in_item;
			res_q.out_time    <= '0;
			res_q.out_node_id <= '0;
			res_q.out_tag     <= '0;
			if (in_item.mode == ceq_pkg::MODE_INSERT) begin
				if (in_item.event_time > late_limit_q) begin
					res_q.status <= ceq_pkg::ST_LATE;
				end else begin
					res_q.status <= ceq_pkg::ST_PAST;
				end
			end else begin
				res_q.status <= ceq_pkg::ST_NOTFOUND;
			end
		end
		if (state_q == S_DIV2 && div_done) begin
			bkt_q <= new_bkt;
			res_q.status <= ceq_pkg::ST_SKIPPED;
		end
		if (state_q == S_SCAN) begin
			idx_s1 <= scan_q;
			vld_s1 <= valid_q[scan_q];
		end
		if (eval_s1 && hit) begin
			pick_q      <= idx_s1;
			pick_time_q <= rd_entry.etime;
			pick_age_q  <= rd_age;
			pick_node_q <= rd_entry.node;
			pick_tag_q  <= rd_entry.handle;
		end
		if (state_q == S_FINISH) begin
			case (item_q.mode)
				ceq_pkg::MODE_INSERT: begin
					res_q.status <= found_q ? ceq_pkg::ST_INSERTED : ceq_pkg::ST_FULL;
				end
				ceq_pkg::MODE_GET: begin
					if (due) begin
						res_q.status      <= ceq_pkg::ST_DELIVERED;
						res_q.out_time    <= pick_time_q;
						res_q.out_node_id <= pick_node_q;
						res_q.out_tag     <= pick_tag_q;
					end else begin
						res_q.status <= ceq_pkg::ST_NONE;
					end
				end
				ceq_pkg::MODE_REMOVE: begin
					res_q.status <= found_q ? ceq_pkg::ST_REMOVED : ceq_pkg::ST_NOTFOUND;
				end
				default: res_q.status <= ceq_pkg::ST_NOTFOUND;
			endcase
		end
		if (state_q == S_RESP && (!out_valid_q || !out_stall)) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule
